[sv/att_pkg.sv]
// att_pkg: shared types and codes for the alarm timer table
// request and result codes, field widths and the result item struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    localparam int TICK_W = 64;
    localparam int KEY_W  = 16;
    localparam int SLOT_W = 5;

    // request types
    localparam logic [1:0] REQ_SET_ONCE     = 2'd0;
    localparam logic [1:0] REQ_SET_PERIODIC = 2'd1;
    localparam logic [1:0] REQ_CANCEL       = 2'd2;
    localparam logic [1:0] REQ_ADVANCE      = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic              status;
        logic [KEY_W-1:0]  fired_key;
        logic [SLOT_W-1:0] slot_index;
        logic [TICK_W-1:0] now_ticks;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

[sv/att_engine.sv]
// att_engine: slot memory, used flags, tick clock and the scan sequencer
// depends on att_pkg
`timescale 1ns / 1ps
`default_nettype none

module att_engine
    import att_pkg::*;
#(
    parameter int NUM_SLOTS = 32,
    parameter int KEY_BITS  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [KEY_W-1:0]  alarm_key,
    input  wire logic [TICK_W-1:0] delay,
    input  wire logic [TICK_W-1:0] repeat_period,
    input  wire logic [TICK_W-1:0] step,
    input  wire logic              load_ok,
    output logic                   emit,
    output res_t                   res
);

    localparam int IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int ENT_W = KW + 2 * TICK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // slot memory: {key, deadline, period}
    logic [ENT_W-1:0] mem [0:NUM_SLOTS-1];
    logic [ENT_W-1:0] rdata_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [1:0]           state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [TICK_W-1:0]    now_reg, now_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        found_idx_reg, found_idx_next;
    logic                 free_reg, free_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;

    // latched request payload
    logic [1:0]        req_reg;
    logic [KW-1:0]     key_reg;
    logic [TICK_W-1:0] delay_reg;
    logic [TICK_W-1:0] period_reg;

    logic [KW-1:0]     rd_key;
    logic [TICK_W-1:0] rd_deadline;
    logic [TICK_W-1:0] rd_period;
    logic              cur_used, hit, due, is_last, is_adv;
    logic              found_any, free_any;
    logic [IW-1:0]     found_sel, free_sel, slot_sel;
    logic [IW+SLOT_W-1:0] idx_ext, sel_ext;
    logic [KW+KEY_W-1:0]  key_ext, rdkey_ext;
    logic              accept, step_ok;

    assign rd_key      = rdata_reg[ENT_W-1 -: KW];
    assign rd_deadline = rdata_reg[2*TICK_W-1 -: TICK_W];
    assign rd_period   = rdata_reg[TICK_W-1:0];

    assign cur_used  = used_reg[idx_reg];
    assign hit       = cur_used && (rd_key == key_reg);
    assign due       = cur_used && (rd_deadline <= now_reg);
    assign is_last   = (idx_reg == LAST_IDX);
    assign is_adv    = (req_reg == REQ_ADVANCE);
    assign found_any = found_reg || hit;
    assign found_sel = found_reg ? found_idx_reg : idx_reg;
    assign free_any  = free_reg || !cur_used;
    assign free_sel  = free_reg ? free_idx_reg : idx_reg;
    assign slot_sel  = found_any ? found_sel : free_sel;

    assign idx_ext   = {{SLOT_W{1'b0}}, idx_reg};
    assign key_ext   = {{KEY_W{1'b0}}, key_reg};
    assign rdkey_ext = {{KEY_W{1'b0}}, rd_key};

    assign accept = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        now_next       = now_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        req_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg + IW'(1);
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rdata_reg;
        emit           = 1'b0;
        step_ok        = 1'b0;
        sel_ext        = {{SLOT_W{1'b0}}, slot_sel};
        res.kind       = KIND_ACK;
        res.status     = STATUS_OK;
        res.fired_key  = key_ext[KEY_W-1:0];
        res.slot_index = '0;
        res.now_ticks  = now_reg;
        res.last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = '0;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    found_idx_next = '0;
                    free_next      = 1'b0;
                    free_idx_next  = '0;
                    state_next     = ST_SCAN;
                    if (req_type == REQ_ADVANCE)
                        now_next = now_reg + step;
                end
            end
            ST_SCAN:
            begin
                if (is_adv)
                begin
                    step_ok = !due || load_ok;
                    if (due && load_ok)
                    begin
                        emit           = 1'b1;
                        res.kind       = KIND_FIRE;
                        res.fired_key  = rdkey_ext[KEY_W-1:0];
                        res.slot_index = idx_ext[SLOT_W-1:0];
                        res.last       = 1'b0;
                        if (rd_period != '0)
                        begin
                            wr_en   = 1'b1;
                            wr_data = {rd_key, now_reg + rd_period, rd_period};
                        end
                        else
                            used_next[idx_reg] = 1'b0;
                    end
                    if (step_ok)
                    begin
                        if (is_last)
                            state_next = ST_DONE;
                        else
                        begin
                            rd_en    = 1'b1;
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                end
                else if (!is_last)
                begin
                    // lookup pass: remember first key match and first free slot
                    step_ok        = 1'b1;
                    found_next     = found_any;
                    found_idx_next = found_sel;
                    free_next      = free_any;
                    free_idx_next  = free_sel;
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + IW'(1);
                end
                else if (load_ok)
                begin
                    step_ok    = 1'b1;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (req_reg == REQ_CANCEL)
                    begin
                        if (found_any)
                        begin
                            used_next[found_sel] = 1'b0;
                            sel_ext              = {{SLOT_W{1'b0}}, found_sel};
                            res.slot_index       = sel_ext[SLOT_W-1:0];
                        end
                    end
                    else if (found_any || free_any)
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = slot_sel;
                        wr_data             = {key_reg, now_reg + delay_reg,
                                               (req_reg == REQ_SET_PERIODIC) ?
                                               period_reg : {TICK_W{1'b0}}};
                        used_next[slot_sel] = 1'b1;
                        res.slot_index      = sel_ext[SLOT_W-1:0];
                    end
                    else
                        res.status = STATUS_FULL;
                end
            end
            ST_DONE:
            begin
                step_ok = load_ok;
                if (load_ok)
                begin
                    emit          = 1'b1;
                    res.kind      = KIND_DONE;
                    res.fired_key = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            now_reg       <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            now_reg       <= now_next;
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            key_reg    <= alarm_key[KW-1:0];
            delay_reg  <= delay;
            period_reg <= repeat_period;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SCAN)
        else $error("accepted item did not start a scan");

    a_done_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.kind == KIND_DONE) |-> is_adv)
        else $error("done result outside an advance");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!emit && !wr_en))
        else $error("result or write while idle");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !step_ok) |=> ($stable(idx_reg) && state_reg == ST_SCAN))
        else $error("scan moved while stalled on output");

    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> load_ok)
        else $error("result emitted into a full output register");

endmodule

`default_nettype wire

[sv/att_out_reg.sv]
// att_out_reg: output register for result items with valid/ready
// depends on att_pkg
`timescale 1ns / 1ps
`default_nettype none

module att_out_reg
    import att_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic emit,
    input  wire res_t res_in,
    output logic      load_ok,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res_out
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign load_ok   = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_out   = data_reg;

    always_comb
    begin
        if (emit)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            data_reg <= res_in;
    end

endmodule

`default_nettype wire

[sv/alarm_timer_table_unit.sv]
// alarm_timer_table_unit: set / cancel / advance requests over a table of alarm slots
// a set or cancel scans every slot and then yields one ack item; an advance scans every
// slot, emits a fire item per due slot and ends with a done item; a full output register
// stalls the scan, and a new request is taken only in idle, after its last item is emitted
// reset: clock to zero, every slot free; slot memory contents are not cleared
// depends on att_pkg, att_engine, att_out_reg
`timescale 1ns / 1ps
`default_nettype none

module alarm_timer_table_unit
    import att_pkg::*;
#(
    parameter int NUM_SLOTS = 32,
    parameter int KEY_BITS  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [KEY_W-1:0]  alarm_key,
    input  wire logic [TICK_W-1:0] delay,
    input  wire logic [TICK_W-1:0] repeat_period,
    input  wire logic [TICK_W-1:0] step,
    // result channel
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [1:0]             kind,
    output logic                   status,
    output logic [KEY_W-1:0]       fired_key,
    output logic [SLOT_W-1:0]      slot_index,
    output logic [TICK_W-1:0]      now_ticks,
    output logic                   last
);

    // engine to output register
    logic emit;
    logic load_ok;
    res_t res_eng;
    res_t res_q;

    // scan sequencer owns the slot memory, the used flags and the tick clock;
    // it takes a new item only in idle, while a finished item may still wait below
    att_engine #(
        .NUM_SLOTS (NUM_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .alarm_key     (alarm_key),
        .delay         (delay),
        .repeat_period (repeat_period),
        .step          (step),
        .load_ok       (load_ok),
        .emit          (emit),
        .res           (res_eng)
    );

    // single output register, reloads in the cycle it is drained
    att_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .res_in    (res_eng),
        .load_ok   (load_ok),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_out   (res_q)
    );

    assign kind       = res_q.kind;
    assign status     = res_q.status;
    assign fired_key  = res_q.fired_key;
    assign slot_index = res_q.slot_index;
    assign now_ticks  = res_q.now_ticks;
    assign last       = res_q.last;

endmodule

`default_nettype wire

[tb/tb_alarm_timer_table_unit.sv]
// tb_alarm_timer_table_unit: self-checking testbench for the alarm timer table
// a clocked driver and monitor around i_dut, with a predictor that scores every result item
// depends on att_pkg and alarm_timer_table_unit
`timescale 1ns / 1ps

module tb_alarm_timer_table_unit;
    import att_pkg::*;

    localparam int SLOTS     = 32;
    localparam int KEY_BITS  = 16;
    localparam int RAND_REQS = 320;
    localparam logic [KEY_W-1:0]  KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // kinds of random stretch
    typedef enum int {EP_MIX, EP_FILL, EP_NOISE, EP_WRAP, EP_SWEEP} episode_t;

    typedef struct {
        logic [1:0]        rt;
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] dly;
        logic [TICK_W-1:0] per;
        logic [TICK_W-1:0] stp;
    } req_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [1:0]        req_type = REQ_SET_ONCE;
    logic [KEY_W-1:0]  alarm_key = '0;
    logic [TICK_W-1:0] delay = '0;
    logic [TICK_W-1:0] repeat_period = '0;
    logic [TICK_W-1:0] step = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [1:0]        kind;
    logic              status;
    logic [KEY_W-1:0]  fired_key;
    logic [SLOT_W-1:0] slot_index;
    logic [TICK_W-1:0] now_ticks;
    logic              last;

    // stimulus waiting for the driver, results waiting for the monitor
    req_item_t request_queue[$];
    res_t      expected_results[$];
    bit        armed_keys[logic [KEY_W-1:0]];
    int        err_count = 0;

    // predictor copy of the alarm table
    logic [TICK_W-1:0] clock_now;
    logic              slot_busy[SLOTS];
    logic [KEY_W-1:0]  slot_id[SLOTS];
    logic [TICK_W-1:0] slot_due[SLOTS];
    logic [TICK_W-1:0] slot_rate[SLOTS];

    // sender burst / gap counters
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern
    int stall_left = 0;
    int rx_mode    = 0;
    int mode_left  = 0;

    alarm_timer_table_unit #(
        .NUM_SLOTS (SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .alarm_key     (alarm_key),
        .delay         (delay),
        .repeat_period (repeat_period),
        .step          (step),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .kind          (kind),
        .status        (status),
        .fired_key     (fired_key),
        .slot_index    (slot_index),
        .now_ticks     (now_ticks),
        .last          (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [TICK_W-1:0] rand_ticks();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_request(logic [1:0] rt, logic [KEY_W-1:0] key,
                                          logic [TICK_W-1:0] dly, logic [TICK_W-1:0] per,
                                          logic [TICK_W-1:0] stp);
        req_item_t itm;
        itm = '{rt: rt, key: key, dly: dly, per: per, stp: stp};
        request_queue.push_back(itm);
        // remember every key that may hold a slot so a sweep can free it
        if (rt == REQ_SET_ONCE || rt == REQ_SET_PERIODIC)
            armed_keys[key & KEY_MASK] = 1'b1;
    endfunction

    function automatic void push_result(logic [1:0] k, logic s, logic [KEY_W-1:0] key,
                                        int slot, logic lst);
        res_t r;
        r = {k, s, key, slot[SLOT_W-1:0], clock_now, lst};
        expected_results.push_back(r);
    endfunction

    function automatic int lookup_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i] && slot_id[i] == key)
                return i;
        return -1;
    endfunction

    // work out every result item one accepted request causes
    function automatic void predict_alarm_results(logic [1:0] rt, logic [KEY_W-1:0] key_in,
                                                  logic [TICK_W-1:0] dly,
                                                  logic [TICK_W-1:0] per,
                                                  logic [TICK_W-1:0] stp);
        logic [KEY_W-1:0] key;
        int               idx;
        key = key_in & KEY_MASK;
        case (rt)
            REQ_SET_ONCE, REQ_SET_PERIODIC:
            begin
                idx = lookup_key(key);
                if (idx < 0)
                begin
                    // lowest free slot
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_busy[i] && idx < 0)
                            idx = i;
                    if (idx >= 0)
                    begin
                        slot_busy[idx] = 1'b1;
                        slot_id[idx]   = key;
                    end
                end
                if (idx < 0)
                    push_result(KIND_ACK, STATUS_FULL, key, 0, 1'b1);
                else
                begin
                    slot_rate[idx] = (rt == REQ_SET_PERIODIC) ? per : '0;
                    slot_due[idx]  = clock_now + dly;
                    push_result(KIND_ACK, STATUS_OK, key, idx, 1'b1);
                end
            end
            REQ_CANCEL:
            begin
                idx = lookup_key(key);
                if (idx >= 0)
                    slot_busy[idx] = 1'b0;
                push_result(KIND_ACK, STATUS_OK, key, (idx >= 0) ? idx : 0, 1'b1);
            end
            default:
            begin
                clock_now = clock_now + stp;
                // one pass in slot order, so a wrapped rearm fires only once
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_busy[i] && slot_due[i] <= clock_now)
                    begin
                        if (slot_rate[i] != 0)
                            slot_due[i] = clock_now + slot_rate[i];
                        else
                            slot_busy[i] = 1'b0;
                        push_result(KIND_FIRE, STATUS_OK, slot_id[i], i, 1'b0);
                    end
                end
                push_result(KIND_DONE, STATUS_OK, '0, 0, 1'b1);
            end
        endcase
    endfunction

    // request driver: bursts of items with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        req_item_t nxt;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                predict_alarm_results(req_type, alarm_key, delay, repeat_period, step);
            // a new item may go out once the current one is gone
            if (!req_valid || req_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    nxt = request_queue.pop_front();
                    req_valid     <= 1'b1;
                    req_type      <= nxt.rt;
                    alarm_key     <= nxt.key;
                    delay         <= nxt.dly;
                    repeat_period <= nxt.per;
                    step          <= nxt.stp;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
            rx_mode    <= 0;
            mode_left  <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = {kind, status, fired_key, slot_index, now_ticks, last};
                if (expected_results.size() == 0)
                begin
                    if (err_count < 10)
                    begin
                        $write("unexpected result item: kind=%0d status=%0d key=%h ",
                               got.kind, got.status, got.fired_key);
                        $display("slot=%0d now=%h last=%0d",
                                 got.slot_index, got.now_ticks, got.last);
                    end
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.fired_key !== want.fired_key || got.slot_index !== want.slot_index ||
                        got.now_ticks !== want.now_ticks || got.last !== want.last)
                    begin
                        if (err_count < 10)
                        begin
                            $write("mismatch exp: kind=%0d status=%0d key=%h ",
                                   want.kind, want.status, want.fired_key);
                            $display("slot=%0d now=%h last=%0d",
                                     want.slot_index, want.now_ticks, want.last);
                            $write("         got: kind=%0d status=%0d key=%h ",
                                   got.kind, got.status, got.fired_key);
                            $display("slot=%0d now=%h last=%0d",
                                     got.slot_index, got.now_ticks, got.last);
                        end
                        err_count++;
                    end
                end
            end
            // modes: always ready, frequent short stalls, rare long stalls
            if (mode_left == 0)
            begin
                rx_mode   <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 300);
            end
            else
                mode_left <= mode_left - 1;
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else if (rx_mode == 1 && $urandom_range(0, 2) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                res_ready  <= 1'b0;
            end
            else if (rx_mode == 2 && $urandom_range(0, 15) == 0)
            begin
                stall_left <= $urandom_range(3, 8);
                res_ready  <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    initial
    begin
        // the worst case ends well before this timeout
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int        directed_n;
        int        pick;
        episode_t  ep;
        bit        first_ep;
        logic [1:0]        rt;
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] dly;
        logic [TICK_W-1:0] per;
        logic [TICK_W-1:0] stp;

        clock_now = '0;
        foreach (slot_busy[i])
        begin
            slot_busy[i] = 1'b0;
            slot_id[i]   = '0;
            slot_due[i]  = '0;
            slot_rate[i] = '0;
        end

        // directed: field extremes, slot reuse, absent cancel, zero period, wraps
        queue_request(REQ_SET_ONCE,     16'h0000, '0,        '0,       '0);
        queue_request(REQ_SET_PERIODIC, 16'hFFFF, 64'd5,     64'd3,    '0);
        queue_request(REQ_SET_PERIODIC, 16'h1234, 64'd10,    '0,       '0);
        queue_request(REQ_SET_ONCE,     16'h00FF, 64'd7,     TICK_MAX, TICK_MAX);
        queue_request(REQ_SET_PERIODIC, 16'hFFFF, 64'd2,     64'd4,    '0);
        queue_request(REQ_CANCEL,       16'hABCD, TICK_MAX,  TICK_MAX, TICK_MAX);
        queue_request(REQ_CANCEL,       16'h00FF, '0,        '0,       '0);
        queue_request(REQ_SET_ONCE,     16'h5555, TICK_MAX,  '0,       '0);
        queue_request(REQ_ADVANCE,      16'hFFFF, TICK_MAX,  TICK_MAX, '0);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       64'd3);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       64'd10);
        // rearm wraps past the clock: fires once per advance
        queue_request(REQ_SET_PERIODIC, 16'h2222, 64'd1,     TICK_MAX, '0);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       64'd1);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       64'd1);
        queue_request(REQ_CANCEL,       16'h2222, '0,        '0,       '0);
        queue_request(REQ_CANCEL,       16'h5555, '0,        '0,       '0);
        queue_request(REQ_CANCEL,       16'hFFFF, '0,        '0,       '0);
        // clock wraps, then a deadline wraps
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       TICK_MAX);
        queue_request(REQ_SET_ONCE,     16'hAAAA, TICK_MAX,  '0,       '0);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       '0);
        // set and cancel never fire, even when already due
        queue_request(REQ_SET_ONCE,     16'h0F0F, '0,        '0,       '0);
        queue_request(REQ_SET_PERIODIC, 16'hF0F0, '0,        64'd1,    '0);
        queue_request(REQ_CANCEL,       16'h1234, '0,        '0,       '0);
        queue_request(REQ_ADVANCE,      '0,       '0,        '0,       64'd2);
        directed_n = request_queue.size();

        // random part, opened by a run that fills the table
        first_ep = 1'b1;
        while (request_queue.size() < directed_n + RAND_REQS)
        begin
            pick = $urandom_range(0, 19);
            if (first_ep || pick == 0)
                ep = EP_FILL;
            else if (pick < 14)
                ep = EP_MIX;
            else if (pick < 16)
                ep = EP_NOISE;
            else if (pick < 18)
                ep = EP_WRAP;
            else
                ep = EP_SWEEP;
            first_ep = 1'b0;

            if (ep == EP_FILL || ep == EP_SWEEP || armed_keys.size() > 36)
            begin
                foreach (armed_keys[k])
                    queue_request(REQ_CANCEL, k, rand_ticks(), rand_ticks(), rand_ticks());
                armed_keys.delete();
            end

            case (ep)
                EP_FILL:
                begin
                    // every slot taken, then two misses, a reuse, and one advance firing all
                    for (int i = 0; i < SLOTS + 2; i++)
                    begin
                        rt = ($urandom_range(0, 2) == 0) ? REQ_SET_ONCE : REQ_SET_PERIODIC;
                        queue_request(rt, 16'(16'h8000 + i), 64'($urandom_range(0, 20)),
                                      64'($urandom_range(1, 10)), rand_ticks());
                    end
                    queue_request(REQ_SET_PERIODIC, 16'h8000, 64'($urandom_range(0, 20)),
                                  64'($urandom_range(0, 10)), '0);
                    queue_request(REQ_ADVANCE, '0, '0, '0, 64'd25);
                    queue_request(REQ_ADVANCE, '0, '0, '0, 64'($urandom_range(1, 10)));
                    foreach (armed_keys[k])
                        queue_request(REQ_CANCEL, k, '0, '0, '0);
                    armed_keys.delete();
                end
                EP_MIX:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        pick = $urandom_range(0, 99);
                        rt = (pick < 35) ? REQ_SET_ONCE :
                             (pick < 60) ? REQ_SET_PERIODIC :
                             (pick < 75) ? REQ_CANCEL : REQ_ADVANCE;
                        key = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'(16'h0100 + $urandom_range(0, 39));
                        pick = $urandom_range(0, 19);
                        dly = (pick < 17) ? 64'($urandom_range(0, 60)) : rand_ticks();
                        pick = $urandom_range(0, 9);
                        per = (pick < 7) ? 64'($urandom_range(1, 40)) :
                              (pick < 8) ? '0 : rand_ticks();
                        pick = $urandom_range(0, 9);
                        stp = (pick < 8) ? 64'($urandom_range(0, 30)) :
                              (pick < 9) ? rand_ticks() : TICK_MAX - $urandom_range(0, 40);
                        queue_request(rt, key, dly, per, stp);
                    end
                end
                EP_NOISE:
                begin
                    for (int i = 0; i < 6; i++)
                        queue_request(2'($urandom), 16'($urandom), rand_ticks(),
                                      rand_ticks(), rand_ticks());
                end
                EP_WRAP:
                begin
                    // deadlines and periods near the top of the tick range
                    queue_request(REQ_SET_PERIODIC, 16'(16'h0100 + $urandom_range(0, 39)),
                                  TICK_MAX - $urandom_range(0, 20),
                                  TICK_MAX - $urandom_range(0, 20), '0);
                    queue_request(REQ_SET_ONCE, 16'(16'h0100 + $urandom_range(0, 39)),
                                  TICK_MAX - $urandom_range(0, 20), '0, '0);
                    queue_request(REQ_ADVANCE, '0, '0, '0, TICK_MAX - $urandom_range(0, 30));
                    queue_request(REQ_ADVANCE, '0, '0, '0, 64'($urandom_range(0, 40)));
                end
                default:
                begin
                    queue_request(REQ_ADVANCE, '0, '0, '0, 64'($urandom_range(0, 50)));
                end
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent and every result item back; checked between edges
        while (request_queue.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
        // quiet window: a stray result item would show up here
        repeat (2 * (SLOTS + 2) + 20) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
